/* src/rqsc_pkg.sv */
// Shared constants and control types of the quadrilateral-rectangle collision pipeline.
package rqsc_pkg;

    // Corners per shape and number of quadrilateral edge normals that are tested.
    localparam int NUM_CORNERS   = 4;
    localparam int NUM_QUAD_AXES = 2;

    // Load enables of the two register stages that one submodule holds.
    typedef struct packed {
        logic en_first;
        logic en_second;
    } t_stage_pair;

endpackage

/* src/rqsc_setup.sv */
// First pipeline stage: edge normals of the quadrilateral and corners of the rectangle.
module rqsc_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_qx [rqsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0] i_qy [rqsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0] i_left,
    input  logic signed [COORD_BITS-1:0] i_top,
    input  logic        [COORD_BITS-2:0] i_width,
    input  logic        [COORD_BITS-2:0] i_height,
    output logic signed [COORD_BITS-1:0] o_qx [rqsc_pkg::NUM_CORNERS],
    output logic signed [COORD_BITS-1:0] o_qy [rqsc_pkg::NUM_CORNERS],
    output logic signed [COORD_BITS:0]   o_nx [rqsc_pkg::NUM_QUAD_AXES],
    output logic signed [COORD_BITS:0]   o_ny [rqsc_pkg::NUM_QUAD_AXES],
    output logic signed [COORD_BITS:0]   o_bx [2],
    output logic signed [COORD_BITS:0]   o_by [2],
    output logic                         o_wh_nz
);

    localparam int CW = COORD_BITS;

    logic signed [CW-1:0] r_qx [rqsc_pkg::NUM_CORNERS];
    logic signed [CW-1:0] r_qy [rqsc_pkg::NUM_CORNERS];
    logic signed [CW:0]   r_nx [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   r_ny [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   r_bx [2];
    logic signed [CW:0]   r_by [2];
    logic                 r_wh_nz;

    logic signed [CW:0]   n_nx [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   n_ny [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   n_bx [2];
    logic signed [CW:0]   n_by [2];

    // The normal of edge P->Q is (-(Qy-Py), Qx-Px); axis 0 is AB, axis 1 is BC.
    always_comb begin
        for (int a = 0; a < rqsc_pkg::NUM_QUAD_AXES; a++) begin
            n_nx[a] = $signed({i_qy[a][CW-1], i_qy[a]}) - $signed({i_qy[a+1][CW-1], i_qy[a+1]});
            n_ny[a] = $signed({i_qx[a+1][CW-1], i_qx[a+1]}) - $signed({i_qx[a][CW-1], i_qx[a]});
        end
        n_bx[0] = $signed({i_left[CW-1], i_left});
        n_bx[1] = $signed({i_left[CW-1], i_left}) + $signed({2'b00, i_width});
        n_by[0] = $signed({i_top[CW-1], i_top});
        n_by[1] = $signed({i_top[CW-1], i_top}) + $signed({2'b00, i_height});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx    <= i_qx;
            r_qy    <= i_qy;
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_wh_nz <= (|i_width) && (|i_height);
        end
    end

    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_bx    = r_bx;
    assign o_by    = r_by;
    assign o_wh_nz = r_wh_nz;

endmodule

/* src/rqsc_project.sv */
// Second and third pipeline stages: products, projections and the rectangle-axis test.
module rqsc_project #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  rqsc_pkg::t_stage_pair         i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_qx [rqsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0]  i_qy [rqsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS:0]    i_nx [rqsc_pkg::NUM_QUAD_AXES],
    input  logic signed [COORD_BITS:0]    i_ny [rqsc_pkg::NUM_QUAD_AXES],
    input  logic signed [COORD_BITS:0]    i_bx [2],
    input  logic signed [COORD_BITS:0]    i_by [2],
    input  logic                          i_wh_nz,
    output logic signed [2*COORD_BITS+2:0] o_pq [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS],
    output logic signed [2*COORD_BITS+2:0] o_pb [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS],
    output logic                          o_bhit
);

    localparam int CW = COORD_BITS;
    localparam int QW = 2 * CW + 1;  // normal times quadrilateral coordinate
    localparam int BW = 2 * CW + 2;  // normal times rectangle coordinate
    localparam int PW = 2 * CW + 3;  // sum of two products

    logic signed [QW-1:0] r_mqx [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic signed [QW-1:0] r_mqy [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic signed [BW-1:0] r_mbx [rqsc_pkg::NUM_QUAD_AXES][2];
    logic signed [BW-1:0] r_mby [rqsc_pkg::NUM_QUAD_AXES][2];
    logic signed [CW-1:0] r_qx_min, r_qx_max, r_qy_min, r_qy_max;
    logic signed [CW:0]   r_bx [2];
    logic signed [CW:0]   r_by [2];
    logic                 r_wh_nz;

    logic signed [PW-1:0] r_pq [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic signed [PW-1:0] r_pb [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic                 r_bhit;

    logic signed [CW-1:0] n_qx_min, n_qx_max, n_qy_min, n_qy_max;
    logic                 n_bhit;

    function automatic logic signed [CW-1:0] min4(input logic signed [CW-1:0] v [4]);
        logic signed [CW-1:0] lo0, lo1;
        lo0  = (v[1] < v[0]) ? v[1] : v[0];
        lo1  = (v[3] < v[2]) ? v[3] : v[2];
        min4 = (lo1 < lo0) ? lo1 : lo0;
    endfunction

    function automatic logic signed [CW-1:0] max4(input logic signed [CW-1:0] v [4]);
        logic signed [CW-1:0] hi0, hi1;
        hi0  = (v[0] < v[1]) ? v[1] : v[0];
        hi1  = (v[2] < v[3]) ? v[3] : v[2];
        max4 = (hi0 < hi1) ? hi1 : hi0;
    endfunction

    always_comb begin
        n_qx_min = min4(i_qx);
        n_qx_max = max4(i_qx);
        n_qy_min = min4(i_qy);
        n_qy_max = max4(i_qy);
    end

    // Stage two: every product of a normal with a coordinate, one register each.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_first) begin
            for (int a = 0; a < rqsc_pkg::NUM_QUAD_AXES; a++) begin
                for (int i = 0; i < rqsc_pkg::NUM_CORNERS; i++) begin
                    r_mqx[a][i] <= QW'(i_nx[a]) * QW'(i_qx[i]);
                    r_mqy[a][i] <= QW'(i_ny[a]) * QW'(i_qy[i]);
                end
                for (int j = 0; j < 2; j++) begin
                    r_mbx[a][j] <= BW'(i_nx[a]) * BW'(i_bx[j]);
                    r_mby[a][j] <= BW'(i_ny[a]) * BW'(i_by[j]);
                end
            end
            r_qx_min <= n_qx_min;
            r_qx_max <= n_qx_max;
            r_qy_min <= n_qy_min;
            r_qy_max <= n_qy_max;
            r_bx     <= i_bx;
            r_by     <= i_by;
            r_wh_nz  <= i_wh_nz;
        end
    end

    // The rectangle's own normals are positive multiples of the x and y axes, so their
    // projections keep the order of the plain coordinates; a zero width or height
    // collapses that axis to a point and no strict overlap can exist.
    always_comb begin
        n_bhit = r_wh_nz
            && ($signed({r_qx_min[CW-1], r_qx_min}) < r_bx[1])
            && (r_bx[0] < $signed({r_qx_max[CW-1], r_qx_max}))
            && ($signed({r_qy_min[CW-1], r_qy_min}) < r_by[1])
            && (r_by[0] < $signed({r_qy_max[CW-1], r_qy_max}));
    end

    // Stage three: projections of the four corners of each shape.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_second) begin
            for (int a = 0; a < rqsc_pkg::NUM_QUAD_AXES; a++) begin
                for (int i = 0; i < rqsc_pkg::NUM_CORNERS; i++) begin
                    r_pq[a][i] <= PW'(r_mqx[a][i]) + PW'(r_mqy[a][i]);
                end
                for (int j = 0; j < 2; j++) begin
                    for (int m = 0; m < 2; m++) begin
                        r_pb[a][2*j+m] <= PW'(r_mbx[a][j]) + PW'(r_mby[a][m]);
                    end
                end
            end
            r_bhit <= n_bhit;
        end
    end

    assign o_pq   = r_pq;
    assign o_pb   = r_pb;
    assign o_bhit = r_bhit;

endmodule

/* src/rqsc_span.sv */
// Fourth and fifth pipeline stages: projection intervals and the final overlap decision.
module rqsc_span #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  rqsc_pkg::t_stage_pair          i_ctl,
    input  logic signed [2*COORD_BITS+2:0] i_pq [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS],
    input  logic signed [2*COORD_BITS+2:0] i_pb [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS],
    input  logic                           i_bhit,
    output logic                           o_bhit,
    output logic                           o_hit
);

    localparam int PW = 2 * COORD_BITS + 3;

    logic signed [PW-1:0] r_pmin [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [PW-1:0] r_pmax [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [PW-1:0] r_tmin [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [PW-1:0] r_tmax [rqsc_pkg::NUM_QUAD_AXES];
    logic                 r_bhit;
    logic                 r_hit;
    logic                 n_hit;

    function automatic logic signed [PW-1:0] min4(input logic signed [PW-1:0] v [4]);
        logic signed [PW-1:0] lo0, lo1;
        lo0  = (v[1] < v[0]) ? v[1] : v[0];
        lo1  = (v[3] < v[2]) ? v[3] : v[2];
        min4 = (lo1 < lo0) ? lo1 : lo0;
    endfunction

    function automatic logic signed [PW-1:0] max4(input logic signed [PW-1:0] v [4]);
        logic signed [PW-1:0] hi0, hi1;
        hi0  = (v[0] < v[1]) ? v[1] : v[0];
        hi1  = (v[2] < v[3]) ? v[3] : v[2];
        max4 = (hi0 < hi1) ? hi1 : hi0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_first) begin
            for (int a = 0; a < rqsc_pkg::NUM_QUAD_AXES; a++) begin
                r_pmin[a] <= min4(i_pq[a]);
                r_pmax[a] <= max4(i_pq[a]);
                r_tmin[a] <= min4(i_pb[a]);
                r_tmax[a] <= max4(i_pb[a]);
            end
            r_bhit <= i_bhit;
        end
    end

    // Strict overlap: intervals that only touch at an end point are separated.
    always_comb begin
        n_hit = r_bhit;
        for (int a = 0; a < rqsc_pkg::NUM_QUAD_AXES; a++) begin
            n_hit = n_hit && (r_pmin[a] < r_tmax[a]) && (r_tmin[a] < r_pmax[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_second) begin
            r_hit <= n_hit;
        end
    end

    assign o_bhit = r_bhit;
    assign o_hit  = r_hit;

endmodule

/* src/rect_quad_sat_collision.sv */
// Top level of the separating-axis collision test between a quadrilateral and a rectangle.
// This block takes one transaction per clock cycle while its output is not stalled and
// returns one flag that tells whether a quadrilateral given by corners A, B, C and D
// (clockwise) overlaps an axis-aligned rectangle given by left, top, width and height.
// All coordinates share one fixed-point format, so the test is exact. The pipeline
// stages are normals and corners, products, projections, intervals and decision, and
// the throughput of one transaction per cycle is set by the fully parallel bank of
// projection multipliers in the second stage. Shapes that only touch, and rectangles
// of zero width or height, report no collision. A stalled output holds the pipeline in
// place: each stage advances when the stage after it is empty or advancing, so bubbles
// are squeezed out and nothing is lost or repeated.
module rect_quad_sat_collision #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_quad_a_x,
    input  logic signed [COORD_BITS-1:0] i_quad_a_y,
    input  logic signed [COORD_BITS-1:0] i_quad_b_x,
    input  logic signed [COORD_BITS-1:0] i_quad_b_y,
    input  logic signed [COORD_BITS-1:0] i_quad_c_x,
    input  logic signed [COORD_BITS-1:0] i_quad_c_y,
    input  logic signed [COORD_BITS-1:0] i_quad_d_x,
    input  logic signed [COORD_BITS-1:0] i_quad_d_y,
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_top,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_collided
);

    localparam int CW = COORD_BITS;
    localparam int PW = 2 * CW + 3;

    // Valid bits of the five stages; they travel alongside the data registers.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    logic signed [CW-1:0] in_qx [rqsc_pkg::NUM_CORNERS];
    logic signed [CW-1:0] in_qy [rqsc_pkg::NUM_CORNERS];

    logic signed [CW-1:0] s1_qx [rqsc_pkg::NUM_CORNERS];
    logic signed [CW-1:0] s1_qy [rqsc_pkg::NUM_CORNERS];
    logic signed [CW:0]   s1_nx [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   s1_ny [rqsc_pkg::NUM_QUAD_AXES];
    logic signed [CW:0]   s1_bx [2];
    logic signed [CW:0]   s1_by [2];
    logic                 s1_wh_nz;

    logic signed [PW-1:0] s3_pq [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic signed [PW-1:0] s3_pb [rqsc_pkg::NUM_QUAD_AXES][rqsc_pkg::NUM_CORNERS];
    logic                 s3_bhit;
    logic                 s4_bhit;

    rqsc_pkg::t_stage_pair ctl_proj;
    rqsc_pkg::t_stage_pair ctl_span;

    // Stage enables: the last stage loads when the output is empty or being taken, and
    // each earlier stage loads when its successor is empty or loading too.
    always_comb begin
        en5 = !r_v5 || i_ready;
        en4 = !r_v4 || en5;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        ctl_proj.en_first  = en2;
        ctl_proj.en_second = en3;
        ctl_span.en_first  = en4;
        ctl_span.en_second = en5;
    end

    assign o_ready = en1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_comb begin
        in_qx[0] = i_quad_a_x;
        in_qy[0] = i_quad_a_y;
        in_qx[1] = i_quad_b_x;
        in_qy[1] = i_quad_b_y;
        in_qx[2] = i_quad_c_x;
        in_qy[2] = i_quad_c_y;
        in_qx[3] = i_quad_d_x;
        in_qy[3] = i_quad_d_y;
    end

    rqsc_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_qx     (in_qx),
        .i_qy     (in_qy),
        .i_left   (i_box_left),
        .i_top    (i_box_top),
        .i_width  (i_box_width),
        .i_height (i_box_height),
        .o_qx     (s1_qx),
        .o_qy     (s1_qy),
        .o_nx     (s1_nx),
        .o_ny     (s1_ny),
        .o_bx     (s1_bx),
        .o_by     (s1_by),
        .o_wh_nz  (s1_wh_nz)
    );

    rqsc_project #(
        .COORD_BITS (COORD_BITS)
    ) u_project (
        .i_clk   (i_clk),
        .i_ctl   (ctl_proj),
        .i_qx    (s1_qx),
        .i_qy    (s1_qy),
        .i_nx    (s1_nx),
        .i_ny    (s1_ny),
        .i_bx    (s1_bx),
        .i_by    (s1_by),
        .i_wh_nz (s1_wh_nz),
        .o_pq    (s3_pq),
        .o_pb    (s3_pb),
        .o_bhit  (s3_bhit)
    );

    rqsc_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .i_clk  (i_clk),
        .i_ctl  (ctl_span),
        .i_pq   (s3_pq),
        .i_pb   (s3_pb),
        .i_bhit (s3_bhit),
        .o_bhit (s4_bhit),
        .o_hit  (o_collided)
    );

`ifndef SYNTHESIS
    // A full pipeline whose output is stalled must refuse new transactions.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready) |-> !o_ready)
        else $error("full pipeline accepted a transaction while stalled");

    // A result can only appear when stage four held a transaction.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v4))
        else $error("result appeared without a transaction behind it");

    // A failed rectangle-axis test must force a miss in the final decision.
    a_box_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !s4_bhit && en5) |=> (o_valid && !o_collided))
        else $error("rectangle-axis separation did not clear the collision flag");
`endif

endmodule

/* tb/sv/tb_rect_quad_sat_collision.sv */
// Self-checking testbench for the quadrilateral-rectangle separating-axis collision block.
`timescale 1ns / 1ps

module tb_rect_quad_sat_collision;

    localparam int COORD_BITS   = 16;
    localparam int NUM_AXES     = rqsc_pkg::NUM_QUAD_AXES + 2;
    localparam int RANDOM_PAIRS = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    // The pipeline is five stages deep; settling after the drain lets any stray result show up.
    localparam int SETTLE_CYCLES = 12;

    // One transaction on the input side: a quadrilateral and an axis-aligned rectangle.
    typedef struct {
        logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [COORD_BITS-1:0] left, top;
        logic        [COORD_BITS-2:0] width, height;
    } t_shape_pair;

    // A row of the directed table. When known_hit is set, the expected flag is typed in
    // by hand; otherwise the predictor supplies it.
    typedef struct {
        t_shape_pair shapes;
        bit          known_hit;
        bit          hit;
    } t_directed_row;

    // What the output side should deliver, tagged with the transaction number.
    typedef struct {
        int unsigned item_no;
        bit          collided;
    } t_hit_record;

    // How a random shape pair is built.
    typedef enum {
        FLAVOR_NOISE,
        FLAVOR_EXTREME,
        FLAVOR_GRID,
        FLAVOR_NEAR
    } t_pair_flavor;

    typedef longint t_corner_vec [rqsc_pkg::NUM_CORNERS];

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [COORD_BITS-1:0] i_quad_a_x, i_quad_a_y, i_quad_b_x, i_quad_b_y;
    logic signed [COORD_BITS-1:0] i_quad_c_x, i_quad_c_y, i_quad_d_x, i_quad_d_y;
    logic signed [COORD_BITS-1:0] i_box_left, i_box_top;
    logic        [COORD_BITS-2:0] i_box_width, i_box_height;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_collided;

    t_hit_record   expected_hits[$];
    t_directed_row directed_rows[$];
    int unsigned   items_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    bit            rst_done = 1'b0;

    rect_quad_sat_collision #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_quad_a_x  (i_quad_a_x),
        .i_quad_a_y  (i_quad_a_y),
        .i_quad_b_x  (i_quad_b_x),
        .i_quad_b_y  (i_quad_b_y),
        .i_quad_c_x  (i_quad_c_x),
        .i_quad_c_y  (i_quad_c_y),
        .i_quad_d_x  (i_quad_d_x),
        .i_quad_d_y  (i_quad_d_y),
        .i_box_left  (i_box_left),
        .i_box_top   (i_box_top),
        .i_box_width (i_box_width),
        .i_box_height(i_box_height),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_collided  (o_collided)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Projects four corners onto the normal (nx, ny) and returns the covered interval.
    // With 16-bit coordinates every product and sum fits easily in 64 bits.
    function automatic void project_corners(input t_corner_vec xs, input t_corner_vec ys,
                                            input longint nx, input longint ny,
                                            output longint lo, output longint hi);
        longint p;
        for (int i = 0; i < rqsc_pkg::NUM_CORNERS; i++) begin
            p = nx * xs[i] + ny * ys[i];
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    // Separating-axis test on the normals of AB, BC and the rectangle's top and right
    // edges. Overlap on an axis is strict, so touching shapes and zero-length edges
    // (whose normal collapses every projection to zero) report no collision.
    function automatic bit predict_collision(input t_shape_pair s);
        t_corner_vec qx, qy, rx, ry;
        longint      nx[NUM_AXES];
        longint      ny[NUM_AXES];
        longint      w, h, pmin, pmax, tmin, tmax;
        bit          hit;
        qx[0] = longint'(s.ax); qy[0] = longint'(s.ay);
        qx[1] = longint'(s.bx); qy[1] = longint'(s.by);
        qx[2] = longint'(s.cx); qy[2] = longint'(s.cy);
        qx[3] = longint'(s.dx); qy[3] = longint'(s.dy);
        w = longint'(s.width);
        h = longint'(s.height);
        rx[0] = longint'(s.left);     ry[0] = longint'(s.top);
        rx[1] = longint'(s.left) + w; ry[1] = longint'(s.top);
        rx[2] = longint'(s.left) + w; ry[2] = longint'(s.top) + h;
        rx[3] = longint'(s.left);     ry[3] = longint'(s.top) + h;
        nx[0] = -(qy[1] - qy[0]); ny[0] = qx[1] - qx[0];
        nx[1] = -(qy[2] - qy[1]); ny[1] = qx[2] - qx[1];
        nx[2] = 0;                ny[2] = w;
        nx[3] = -h;               ny[3] = 0;
        hit = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            project_corners(qx, qy, nx[a], ny[a], pmin, pmax);
            project_corners(rx, ry, nx[a], ny[a], tmin, tmax);
            if (!(pmin < tmax && tmin < pmax)) hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic add_row(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy, input int dx, input int dy,
                           input int left, input int top, input int width,
                           input int height, input bit known_hit, input bit hit);
        t_directed_row row;
        row.shapes.ax = 16'(ax);   row.shapes.ay = 16'(ay);
        row.shapes.bx = 16'(bx);   row.shapes.by = 16'(by);
        row.shapes.cx = 16'(cx);   row.shapes.cy = 16'(cy);
        row.shapes.dx = 16'(dx);   row.shapes.dy = 16'(dy);
        row.shapes.left = 16'(left);
        row.shapes.top = 16'(top);
        row.shapes.width = 15'(width);
        row.shapes.height = 15'(height);
        row.known_hit = known_hit;
        row.hit = hit;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic signed [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            4: return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_BITS-2:0] extreme_size();
        case ($urandom_range(0, 3))
            0: return 15'd0;
            1: return 15'd1;
            2: return 15'h7FFF;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] grid_coord();
        return 16'(int'($urandom_range(0, 12)) - 6);
    endfunction

    // Builds one random shape pair. Most pairs sit close together so that every axis
    // matters; grid pairs make touching and degenerate cases common; noise and extreme
    // pairs exercise the full value range and every bit of every field.
    function automatic t_shape_pair random_pair();
        t_shape_pair  s;
        t_pair_flavor flavor;
        int           pick, cx, cy;
        pick = int'($urandom_range(0, 99));
        if (pick < 10) flavor = FLAVOR_NOISE;
        else if (pick < 20) flavor = FLAVOR_EXTREME;
        else if (pick < 45) flavor = FLAVOR_GRID;
        else flavor = FLAVOR_NEAR;
        case (flavor)
            FLAVOR_NOISE: begin
                s.ax = 16'($urandom); s.ay = 16'($urandom);
                s.bx = 16'($urandom); s.by = 16'($urandom);
                s.cx = 16'($urandom); s.cy = 16'($urandom);
                s.dx = 16'($urandom); s.dy = 16'($urandom);
                s.left = 16'($urandom); s.top = 16'($urandom);
                s.width = 15'($urandom); s.height = 15'($urandom);
            end
            FLAVOR_EXTREME: begin
                s.ax = extreme_coord(); s.ay = extreme_coord();
                s.bx = extreme_coord(); s.by = extreme_coord();
                s.cx = extreme_coord(); s.cy = extreme_coord();
                s.dx = extreme_coord(); s.dy = extreme_coord();
                s.left = extreme_coord(); s.top = extreme_coord();
                s.width = extreme_size(); s.height = extreme_size();
            end
            FLAVOR_GRID: begin
                s.ax = grid_coord(); s.ay = grid_coord();
                s.bx = grid_coord(); s.by = grid_coord();
                s.cx = grid_coord(); s.cy = grid_coord();
                s.dx = grid_coord(); s.dy = grid_coord();
                s.left = grid_coord(); s.top = grid_coord();
                s.width = 15'($urandom_range(0, 6));
                s.height = 15'($urandom_range(0, 6));
            end
            default: begin
                // A tilted quadrilateral around a random center, one corner per
                // quadrant in clockwise order, and a rectangle nearby.
                cx = int'($urandom_range(0, 4000)) - 2000;
                cy = int'($urandom_range(0, 4000)) - 2000;
                s.ax = 16'(cx - int'($urandom_range(0, 300)));
                s.ay = 16'(cy - int'($urandom_range(0, 300)));
                s.bx = 16'(cx + int'($urandom_range(0, 300)));
                s.by = 16'(cy - int'($urandom_range(0, 300)));
                s.cx = 16'(cx + int'($urandom_range(0, 300)));
                s.cy = 16'(cy + int'($urandom_range(0, 300)));
                s.dx = 16'(cx - int'($urandom_range(0, 300)));
                s.dy = 16'(cy + int'($urandom_range(0, 300)));
                s.left = 16'(cx + int'($urandom_range(0, 600)) - 400);
                s.top = 16'(cy + int'($urandom_range(0, 600)) - 400);
                s.width = ($urandom_range(0, 19) == 0) ? 15'd0 : 15'($urandom_range(1, 400));
                s.height = ($urandom_range(0, 19) == 0) ? 15'd0 : 15'($urandom_range(1, 400));
            end
        endcase
        return s;
    endfunction

    // Offers one transaction after an idle gap and records the expected flag once the
    // block takes it. Valid is lowered only for a real gap, so back-to-back transactions
    // keep it high without a second assignment in the same time step.
    task automatic send_pair(input t_shape_pair s, input bit known_hit, input bit hit,
                             input int gap);
        t_hit_record rec;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_quad_a_x   <= s.ax;
        i_quad_a_y   <= s.ay;
        i_quad_b_x   <= s.bx;
        i_quad_b_y   <= s.by;
        i_quad_c_x   <= s.cx;
        i_quad_c_y   <= s.cy;
        i_quad_d_x   <= s.dx;
        i_quad_d_y   <= s.dy;
        i_box_left   <= s.left;
        i_box_top    <= s.top;
        i_box_width  <= s.width;
        i_box_height <= s.height;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        rec.item_no = items_sent;
        rec.collided = known_hit ? hit : predict_collision(s);
        expected_hits.insert(expected_hits.size(), rec);
        items_sent++;
    endtask

    // Holds off the sender until every transaction in flight has come out.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hits.size() != 0) @(posedge i_clk);
    endtask

    // Output side: a random stall before each result, with one stretch of full
    // throughput. Each accepted result is checked against the oldest expectation.
    initial begin
        int          stall;
        t_hit_record rec;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!rst_done);
        forever begin
            if (results_seen >= 500 && results_seen < 650) stall = 0;
            else stall = int'($urandom_range(0, 9));
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            results_seen++;
            if (expected_hits.size() == 0) begin
                error_count++;
                $display("%0t: result with no transaction pending: expected none, actual %0d",
                         $time, o_collided);
            end else begin
                rec = expected_hits.pop_front();
                if (o_collided !== rec.collided) begin
                    error_count++;
                    $display("%0t: transaction %0d collided mismatch: expected %0d, actual %0d",
                             $time, rec.item_no, rec.collided, o_collided);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int gap;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_quad_a_x   <= '0;
        i_quad_a_y   <= '0;
        i_quad_b_x   <= '0;
        i_quad_b_y   <= '0;
        i_quad_c_x   <= '0;
        i_quad_c_y   <= '0;
        i_quad_d_x   <= '0;
        i_quad_d_y   <= '0;
        i_box_left   <= '0;
        i_box_top    <= '0;
        i_box_width  <= '0;
        i_box_height <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;
        @(posedge i_clk);

        // Directed table. The unit square here is 10 pixels on a side in Q12.4.
        // Plain overlap, then identical shapes, where the two minimums are equal.
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 160, 160, 1, 1);
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 0, 0, 160, 160, 1, 1);
        // Shapes that only touch along an edge do not collide.
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 160, 0, 160, 160, 1, 0);
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 0, 160, 160, 160, 1, 0);
        // A rectangle of zero width or zero height never collides.
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 0, 160, 1, 0);
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 160, 0, 1, 0);
        // Zero-length AB or BC edge, and everything at zero.
        add_row(0, 0, 0, 0, 160, 160, 0, 160, 40, 40, 40, 40, 1, 0);
        add_row(0, 0, 160, 0, 160, 0, 0, 160, 40, 40, 40, 40, 1, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        // Far apart, rectangle inside the quadrilateral, quadrilateral inside the rectangle.
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 1000, 1000, 100, 100, 1, 0);
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 40, 40, 16, 16, 1, 1);
        add_row(0, 0, 160, 0, 160, 160, 0, 160, -100, -100, 400, 400, 1, 1);
        // A quadrilateral spanning the whole coordinate range against extreme rectangles.
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                0, 0, 16, 16, 1, 1);
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                32767, 32767, 32767, 32767, 1, 0);
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                -32768, -32768, 32767, 32767, 1, 1);
        // A diamond: separated only along a diagonal axis, a box at its center, then one for the predictor.
        add_row(0, -160, 160, 0, 0, 160, -160, 0, 100, 100, 100, 100, 1, 0);
        add_row(0, -160, 160, 0, 0, 160, -160, 0, -20, -20, 40, 40, 1, 1);
        add_row(0, -160, 160, 0, 0, 160, -160, 0, 60, 60, 100, 100, 0, 0);
        // All corners at one extreme point.
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                0, 0, 32767, 32767, 1, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, 32767, 32767, 1, 0);
        // The widest rectangle, ending one step short of the square.
        add_row(0, 0, 160, 0, 160, 160, 0, 160, -32768, 0, 32767, 16, 1, 0);
        // Tilted, reversed winding and mixed extremes go through the predictor.
        add_row(10, -50, 120, 30, 40, 140, -70, 60, 30, 20, 50, 50, 0, 0);
        add_row(0, 0, 0, 160, 160, 160, 160, 0, 80, 80, 160, 160, 0, 0);
        add_row(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
                -1, -1, 32767, 1, 0, 0);

        foreach (directed_rows[r]) begin
            send_pair(directed_rows[r].shapes, directed_rows[r].known_hit,
                      directed_rows[r].hit, int'($urandom_range(0, 9)));
        end
        drain_pipeline();

        // Random traffic with two stretches of back-to-back transactions and one full
        // drain halfway through.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS / 2) drain_pipeline();
            if ((n >= 300 && n < 420) || (n >= 1100 && n < 1200)) gap = 0;
            else gap = int'($urandom_range(0, 9));
            send_pair(random_pair(), 1'b0, 1'b0, gap);
        end

        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
